// File: rtl/pcs_pkg.sv
// Shared types, constants and codes for the streaming correlation block.
`timescale 1ns / 1ps

package pcs_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 16;

    // Quotient of the ratio r^2 * 2^32, saturated, and its integer root.
    localparam int DIVQ_BITS  = 33;
    localparam int FRAC_SHIFT = 32;
    localparam int ROOT_BITS  = 17;

    localparam logic [16:0] R_MAG_MAX      = 17'd32768;
    localparam logic [15:0] R_POS_MAX      = 16'd32767;
    localparam logic [31:0] PAIR_COUNT_MAX = 32'd65535;

    // Q1.15 band thresholds
    localparam logic signed [15:0] TH_P08 = 16'sd26215;
    localparam logic signed [15:0] TH_P06 = 16'sd19661;
    localparam logic signed [15:0] TH_P04 = 16'sd13108;
    localparam logic signed [15:0] TH_P02 = 16'sd6554;
    localparam logic signed [15:0] TH_Z   = 16'sd0;
    localparam logic signed [15:0] TH_N02 = -16'sd6553;
    localparam logic signed [15:0] TH_N04 = -16'sd13107;
    localparam logic signed [15:0] TH_N06 = -16'sd19660;
    localparam logic signed [15:0] TH_N08 = -16'sd26214;

    localparam logic [3:0] BAND_POS_VSTRONG = 4'd0;
    localparam logic [3:0] BAND_POS_STRONG  = 4'd1;
    localparam logic [3:0] BAND_POS_MOD     = 4'd2;
    localparam logic [3:0] BAND_POS_WEAK    = 4'd3;
    localparam logic [3:0] BAND_POS_VWEAK   = 4'd4;
    localparam logic [3:0] BAND_NEG_VWEAK   = 4'd5;
    localparam logic [3:0] BAND_NEG_WEAK    = 4'd6;
    localparam logic [3:0] BAND_NEG_MOD     = 4'd7;
    localparam logic [3:0] BAND_NEG_STRONG  = 4'd8;
    localparam logic [3:0] BAND_NEG_VSTRONG = 4'd9;
    localparam logic [3:0] BAND_UNDEF       = 4'd10;

    typedef struct packed {
        logic signed [15:0] x_sample;
        logic signed [15:0] y_sample;
        logic               last_pair;
    } pcs_in_t;

    typedef struct packed {
        logic signed [15:0] r_value;
        logic [3:0]         strength_band;
        logic [15:0]        pair_count;
    } pcs_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_MUL_LOAD,
        ST_MUL_RUN,
        ST_MUL_FIX,
        ST_MUL_STORE,
        ST_CHECK,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_SQRT_LOAD,
        ST_SQRT_RUN,
        ST_FINISH
    } pcs_state_t;

    // Operand pairs of the shared serial multiplier, in issue order
    typedef enum logic [2:0] {
        MOP_N_SXY,
        MOP_SX_SY,
        MOP_N_SXX,
        MOP_SX_SX,
        MOP_N_SYY,
        MOP_SY_SY,
        MOP_MAG_MAG,
        MOP_D1_D2
    } pcs_mop_t;

    typedef struct packed {
        logic     accept;
        logic     acc_en;
        logic     mul_load;
        logic     mul_step;
        logic     mul_fix;
        logic     mul_store;
        logic     div_load;
        logic     div_step;
        logic     sqrt_load;
        logic     sqrt_step;
        logic     finish;
        pcs_mop_t mop;
    } pcs_cmd_t;

    typedef struct packed {
        logic last;
        logic mul_last;
        logic div_last;
        logic sqrt_last;
        logic undef;
        logic out_free;
    } pcs_stat_t;

endpackage

// File: rtl/pearson_correlation_stream.sv
// Top level of the streaming Pearson correlation block.
`timescale 1ns / 1ps

//  channel  | valid         | stall         | payload
//  ---------+---------------+---------------+--------------------------------------
//  sample   | sample_valid  | sample_stall  | sample: x_sample, y_sample, last_pair
//  result   | result_valid  | result_stall  | result: r_value, strength_band, pair_count
//
//  Each pair is captured with its x*y, x*x, y*y products, then accumulated.
//  A last pair adds the end-of-set work on one shared shift-add multiplier of
//  NW = max(COUNT_BITS+1+SQ, 2*(SAMPLE_BITS+COUNT_BITS))+1 bits,
//  SQ = min(2*SAMPLE_BITS+COUNT_BITS, 64).
//  Six products come first; an undefined set then goes straight to the finish step.
//  Divide is 33 restoring steps, root is 17 bit steps.
//  Reset clears the accumulators and the result valid flag; no clearing pass.
//  A held result stalls the finish step; new pairs are not taken meanwhile.

module pearson_correlation_stream #(
    parameter int SAMPLE_BITS = pcs_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = pcs_pkg::COUNT_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  pcs_pkg::pcs_in_t  sample,
    output logic              result_valid,
    input  logic              result_stall,
    output pcs_pkg::pcs_out_t result
);
    import pcs_pkg::*;

    pcs_cmd_t  cmd;
    pcs_stat_t stat;

    // sequencer: accept, accumulate, then multiply / divide / root steps
    pcs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    // sums, arithmetic units and the result register
    pcs_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// File: rtl/pcs_ctrl.sv
// Sequencer for accumulation and the end-of-set multiply, divide and root steps.
`timescale 1ns / 1ps

module pcs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  pcs_pkg::pcs_stat_t stat,
    output pcs_pkg::pcs_cmd_t  cmd
);
    import pcs_pkg::*;

    pcs_state_t state_reg, state_next;
    pcs_mop_t   mop_reg, mop_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mop_reg   <= MOP_N_SXY;
        end
        else
        begin
            state_reg <= state_next;
            mop_reg   <= mop_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mop_next   = mop_reg;
        cmd        = '0;
        cmd.mop    = mop_reg;
        sample_stall = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                cmd.acc_en = 1'b1;
                mop_next   = MOP_N_SXY;
                state_next = stat.last ? ST_MUL_LOAD : ST_IDLE;
            end
            ST_MUL_LOAD:
            begin
                cmd.mul_load = 1'b1;
                state_next   = ST_MUL_RUN;
            end
            ST_MUL_RUN:
            begin
                cmd.mul_step = 1'b1;
                if (stat.mul_last)
                    state_next = ST_MUL_FIX;
            end
            ST_MUL_FIX:
            begin
                cmd.mul_fix = 1'b1;
                state_next  = ST_MUL_STORE;
            end
            ST_MUL_STORE:
            begin
                cmd.mul_store = 1'b1;
                case (mop_reg)
                    MOP_SY_SY: state_next = ST_CHECK;
                    MOP_D1_D2: state_next = ST_DIV_LOAD;
                    default:
                    begin
                        mop_next   = pcs_mop_t'(mop_reg + 3'd1);
                        state_next = ST_MUL_LOAD;
                    end
                endcase
            end
            ST_CHECK:
            begin
                // degenerate spread skips the ratio entirely
                mop_next   = MOP_MAG_MAG;
                state_next = stat.undef ? ST_FINISH : ST_MUL_LOAD;
            end
            ST_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV_RUN;
            end
            ST_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = ST_SQRT_LOAD;
            end
            ST_SQRT_LOAD:
            begin
                cmd.sqrt_load = 1'b1;
                state_next    = ST_SQRT_RUN;
            end
            ST_SQRT_RUN:
            begin
                cmd.sqrt_step = 1'b1;
                if (stat.sqrt_last)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    mop_next   = MOP_N_SXY;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_acc_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC) |-> $past(cmd.accept))
        else $error("accumulate step without an accepted item");

endmodule

// File: rtl/pcs_datapath.sv
// Accumulators, shared serial multiplier, restoring divider, root and result register.
`timescale 1ns / 1ps

module pcs_datapath #(
    parameter int SAMPLE_BITS = pcs_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = pcs_pkg::COUNT_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pcs_pkg::pcs_in_t  sample,
    input  pcs_pkg::pcs_cmd_t cmd,
    output pcs_pkg::pcs_stat_t stat,
    output logic              result_valid,
    input  logic              result_stall,
    output pcs_pkg::pcs_out_t result
);
    import pcs_pkg::*;

    localparam int SUMW   = SAMPLE_BITS + COUNT_BITS;
    localparam int SQW    = (2 * SAMPLE_BITS + COUNT_BITS > 64) ? 64
                                                               : 2 * SAMPLE_BITS + COUNT_BITS;
    localparam int PRA    = COUNT_BITS + 1 + SQW;
    localparam int PRB    = 2 * SUMW;
    localparam int NW     = ((PRA > PRB) ? PRA : PRB) + 1;
    localparam int PW     = 2 * NW;
    localparam int MCW    = $clog2(NW);
    localparam int DCW    = $clog2(DIVQ_BITS);
    localparam int SBW    = $clog2(ROOT_BITS);

    // sample capture and per-pair products
    logic signed [31:0]            x_wide, y_wide;
    logic signed [SAMPLE_BITS-1:0] x_sb, y_sb;
    logic signed [SAMPLE_BITS-1:0] x_reg, y_reg;
    logic signed [2*SAMPLE_BITS-1:0] xy_reg, xx_reg, yy_reg;
    logic                          last_reg;

    // accumulators
    logic [COUNT_BITS-1:0]  count_reg;
    logic signed [SUMW-1:0] sx_reg, sy_reg;
    logic signed [SQW-1:0]  sxy_reg, sxx_reg, syy_reg;

    // serial multiplier
    logic signed [NW-1:0] opa, opb;
    logic [NW-1:0]        a_abs, b_abs;
    logic [PW-1:0]        mc_reg, prod_reg;
    logic [NW-1:0]        mp_reg;
    logic                 neg_reg;
    logic [MCW-1:0]       mcnt_reg;

    // stored intermediates
    logic [PW-1:0]        tmp_reg, diff;
    logic signed [NW-1:0] num_reg, d1_reg, d2_reg;
    logic [NW-1:0]        mag;
    logic [PW-1:0]        msq_reg, pden_reg;

    // divider
    logic [PW-1:0]          hi_part;
    logic [PW-1:0]          rem_reg;
    logic [PW:0]            dtrial;
    logic                   dge;
    logic [DIVQ_BITS-1:0]   rbit_reg, q_reg;
    logic                   sat_reg;
    logic [DCW-1:0]         dcnt_reg;

    // root
    logic [ROOT_BITS-1:0]   root_reg, trial;
    logic [2*ROOT_BITS-1:0] trial_sq;
    logic [SBW-1:0]         sbit_reg;

    // result
    logic [ROOT_BITS:0]     q_round;
    logic [16:0]            q_mag;
    logic signed [15:0]     r_q;
    logic [31:0]            count_ext;
    logic                   undef;
    logic                   out_valid_reg;
    pcs_out_t               out_reg;

    function automatic logic [3:0] band_of(input logic signed [15:0] r);
        logic [3:0] b;
        if (r >= TH_P08)      b = BAND_POS_VSTRONG;
        else if (r >= TH_P06) b = BAND_POS_STRONG;
        else if (r >= TH_P04) b = BAND_POS_MOD;
        else if (r >= TH_P02) b = BAND_POS_WEAK;
        else if (r >= TH_Z)   b = BAND_POS_VWEAK;
        else if (r >= TH_N02) b = BAND_NEG_VWEAK;
        else if (r >= TH_N04) b = BAND_NEG_WEAK;
        else if (r >= TH_N06) b = BAND_NEG_MOD;
        else if (r >= TH_N08) b = BAND_NEG_STRONG;
        else                  b = BAND_NEG_VSTRONG;
        return b;
    endfunction

    assign x_wide = 32'($signed(sample.x_sample));
    assign y_wide = 32'($signed(sample.y_sample));
    assign x_sb   = x_wide[SAMPLE_BITS-1:0];
    assign y_sb   = y_wide[SAMPLE_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            x_reg  <= x_sb;
            y_reg  <= y_sb;
            xy_reg <= x_sb * y_sb;
            xx_reg <= x_sb * x_sb;
            yy_reg <= y_sb * y_sb;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_reg <= 1'b0;
        else if (cmd.accept)
            last_reg <= sample.last_pair;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sxy_reg   <= '0;
            sxx_reg   <= '0;
            syy_reg   <= '0;
        end
        else if (cmd.finish)
        begin
            count_reg <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sxy_reg   <= '0;
            sxx_reg   <= '0;
            syy_reg   <= '0;
        end
        else if (cmd.acc_en && (count_reg != {COUNT_BITS{1'b1}}))
        begin
            count_reg <= count_reg + 1'b1;
            sx_reg    <= sx_reg + SUMW'(x_reg);
            sy_reg    <= sy_reg + SUMW'(y_reg);
            sxy_reg   <= sxy_reg + SQW'(xy_reg);
            sxx_reg   <= sxx_reg + SQW'(xx_reg);
            syy_reg   <= syy_reg + SQW'(yy_reg);
        end
    end

    assign mag = num_reg[NW-1] ? NW'(-num_reg) : NW'(num_reg);

    always_comb
    begin
        case (cmd.mop)
            MOP_N_SXY:   begin opa = NW'(count_reg); opb = NW'(sxy_reg); end
            MOP_SX_SY:   begin opa = NW'(sx_reg);    opb = NW'(sy_reg);  end
            MOP_N_SXX:   begin opa = NW'(count_reg); opb = NW'(sxx_reg); end
            MOP_SX_SX:   begin opa = NW'(sx_reg);    opb = NW'(sx_reg);  end
            MOP_N_SYY:   begin opa = NW'(count_reg); opb = NW'(syy_reg); end
            MOP_SY_SY:   begin opa = NW'(sy_reg);    opb = NW'(sy_reg);  end
            MOP_MAG_MAG: begin opa = NW'(mag);       opb = NW'(mag);     end
            default:     begin opa = d1_reg;         opb = d2_reg;       end
        endcase
    end

    assign a_abs = opa[NW-1] ? NW'(-opa) : NW'(opa);
    assign b_abs = opb[NW-1] ? NW'(-opb) : NW'(opb);
    assign diff  = tmp_reg - prod_reg;

    // shift-add multiply on magnitudes, sign applied afterwards
    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            mc_reg   <= PW'(a_abs);
            mp_reg   <= b_abs;
            prod_reg <= '0;
            neg_reg  <= opa[NW-1] ^ opb[NW-1];
            mcnt_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            if (mp_reg[0])
                prod_reg <= prod_reg + mc_reg;
            mc_reg   <= mc_reg << 1;
            mp_reg   <= mp_reg >> 1;
            mcnt_reg <= mcnt_reg + 1'b1;
        end
        else if (cmd.mul_fix)
        begin
            if (neg_reg)
                prod_reg <= -prod_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_store)
        begin
            case (cmd.mop)
                MOP_N_SXY, MOP_N_SXX, MOP_N_SYY: tmp_reg  <= prod_reg;
                MOP_SX_SY:                       num_reg  <= diff[NW-1:0];
                MOP_SX_SX:                       d1_reg   <= diff[NW-1:0];
                MOP_SY_SY:                       d2_reg   <= diff[NW-1:0];
                MOP_MAG_MAG:                     msq_reg  <= prod_reg;
                default:                         pden_reg <= prod_reg;
            endcase
        end
    end

    assign undef = d1_reg[NW-1] || (d1_reg == '0) || d2_reg[NW-1] || (d2_reg == '0);

    // quotient of (num^2 << 32) / (d1*d2), saturated to DIVQ_BITS
    assign hi_part = msq_reg >> 1;
    assign dtrial  = {rem_reg, rbit_reg[DIVQ_BITS-1]};
    assign dge     = (dtrial >= {1'b0, pden_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            sat_reg  <= (hi_part >= pden_reg);
            rem_reg  <= hi_part;
            rbit_reg <= {msq_reg[0], {FRAC_SHIFT{1'b0}}};
            q_reg    <= (hi_part >= pden_reg) ? {DIVQ_BITS{1'b1}} : '0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!sat_reg)
            begin
                if (dge)
                begin
                    rem_reg <= PW'(dtrial - {1'b0, pden_reg});
                    q_reg   <= {q_reg[DIVQ_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= dtrial[PW-1:0];
                    q_reg   <= {q_reg[DIVQ_BITS-2:0], 1'b0};
                end
            end
            rbit_reg <= rbit_reg << 1;
            dcnt_reg <= dcnt_reg + 1'b1;
        end
    end

    // integer root, one bit per cycle from the top
    assign trial    = root_reg | (ROOT_BITS'(1) << sbit_reg);
    assign trial_sq = trial * trial;

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_load)
        begin
            root_reg <= '0;
            sbit_reg <= SBW'(ROOT_BITS - 1);
        end
        else if (cmd.sqrt_step)
        begin
            if (trial_sq <= {1'b0, q_reg})
                root_reg <= trial;
            sbit_reg <= sbit_reg - 1'b1;
        end
    end

    // root halved with rounding: q = (root + 1) / 2, clamped to R_MAG_MAX
    assign q_round   = ({1'b0, root_reg} + 1'b1) >> 1;
    assign q_mag     = (q_round[16:0] > R_MAG_MAX || q_round[ROOT_BITS]) ? R_MAG_MAX
                                                                         : q_round[16:0];
    assign count_ext = 32'(count_reg);

    always_comb
    begin
        if (undef)
            r_q = '0;
        else if (num_reg[NW-1])
            r_q = 16'(~q_mag + 1'b1);
        else if (q_mag > {1'b0, R_POS_MAX})
            r_q = R_POS_MAX;
        else
            r_q = q_mag[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_reg.r_value       <= r_q;
            out_reg.strength_band <= undef ? BAND_UNDEF : band_of(r_q);
            out_reg.pair_count    <= (count_ext > PAIR_COUNT_MAX) ? 16'hFFFF
                                                                  : count_ext[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    assign result_valid   = out_valid_reg;
    assign result         = out_reg;
    assign stat.last      = last_reg;
    assign stat.mul_last  = (mcnt_reg == MCW'(NW - 1));
    assign stat.div_last  = (dcnt_reg == DCW'(DIVQ_BITS - 1));
    assign stat.sqrt_last = (sbit_reg == '0);
    assign stat.undef     = undef;
    assign stat.out_free  = !out_valid_reg || !result_stall;

    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (count_reg == '0))
        else $error("accumulators not cleared after result");

    a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step && !sat_reg) |-> (rem_reg < pden_reg))
        else $error("divider remainder out of range");

    a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sqrt_step |=> ((2*ROOT_BITS)'(root_reg * root_reg) <= {1'b0, q_reg}))
        else $error("root overshoots quotient");

endmodule
